// ----- design/acb_pkg.sv -----
// Shared types, constants and the one-bit state update for the ACORN-128 byte decrypt unit.
package acb_pkg;

  // Cipher state and per-beat step count
  localparam int STATE_BITS    = 293;
  localparam int SLICE_BITS    = 64;
  localparam int LAST_BITS     = STATE_BITS - 4 * SLICE_BITS;  // bits in the top slice
  localparam int BITS_PER_ITEM = 8;
  localparam logic [7:0] STEP_MASK = 8'((1 << BITS_PER_ITEM) - 1);

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Function codes
  localparam logic FUNC_DECRYPT = 1'b0;
  localparam logic FUNC_LOAD    = 1'b1;

  // Slice numbers
  localparam logic [2:0] SLICE_0    = 3'd0;
  localparam logic [2:0] SLICE_1    = 3'd1;
  localparam logic [2:0] SLICE_2    = 3'd2;
  localparam logic [2:0] SLICE_3    = 3'd3;
  localparam logic [2:0] SLICE_LAST = 3'd4;

  typedef logic [STATE_BITS-1:0] state_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic                  load;     // slice load, else decrypt
    logic                  load_en;  // slice number in range
    logic [2:0]            slice;
    logic [SLICE_BITS-1:0] word;     // already masked for the top slice
    logic [7:0]            cbyte;
    logic [7:0]            abyte;
    logic [7:0]            bbyte;
  } cmd_t;

  typedef struct packed {
    state_t s;
    logic   ks;
    logic   p;
  } step_t;

  function automatic logic maj3(logic x, logic y, logic z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  function automatic logic ch3(logic x, logic y, logic z);
    return (x & y) ^ (~x & z);
  endfunction

  // One decrypt update: linear taps, keystream, feedback, shift
  function automatic step_t acb_step(state_t s_in, logic c, logic a, logic b);
    state_t t;
    step_t  r;
    logic   ks;
    logic   fb;
    logic   p;
    t = s_in;
    t[289] = s_in[289] ^ s_in[235] ^ s_in[230];
    t[230] = s_in[230] ^ s_in[196] ^ s_in[193];
    t[193] = s_in[193] ^ s_in[160] ^ s_in[154];
    t[154] = s_in[154] ^ s_in[111] ^ s_in[107];
    t[107] = s_in[107] ^ s_in[66]  ^ s_in[61];
    t[61]  = s_in[61]  ^ s_in[23]  ^ s_in[0];
    ks = t[12] ^ t[154] ^ maj3(t[235], t[61], t[193]) ^ ch3(t[230], t[111], t[66]);
    fb = t[0] ^ ~t[107] ^ maj3(t[244], t[23], t[160]) ^ (a & t[196]) ^ (b & ks);
    p  = ks ^ c;
    r.s  = {fb ^ p, t[STATE_BITS-1:1]};
    r.ks = ks;
    r.p  = p;
    return r;
  endfunction

endpackage

// ----- design/acorn128_byte_decrypt_unit.sv -----
// Top level of the ACORN-128 byte decrypt unit: front end, command queue, cipher back end.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | func, load_index, load_word, cipher/ca/cb bytes
//   out_    | output    | out_valid / out_ready | plain_byte, keystream_byte
//
// One beat per cycle sustained while out_ready stays high; each input beat passes through a queue
// entry, then the back end's eight unrolled bit updates into the result register.
// The queue holds two commands and the result register one; with the result register
// full and out_ready low, input takes at most two more beats before in_ready drops.
// Reset clears the 293-bit state to zero and empties the queue and result register.
// A load beat returns a zero result; slice numbers above four leave the state untouched.
module acorn128_byte_decrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [2:0]  in_load_index,
  input  logic [63:0] in_load_word,
  input  logic [7:0]  in_cipher_byte,
  input  logic [7:0]  in_ca_byte,
  input  logic [7:0]  in_cb_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_plain_byte,
  output logic [7:0]  out_keystream_byte
);
  import acb_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  // Classify incoming beats
  acb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_load_index  (in_load_index),
    .in_load_word   (in_load_word),
    .in_cipher_byte (in_cipher_byte),
    .in_ca_byte     (in_ca_byte),
    .in_cb_byte     (in_cb_byte),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  // Decouple front and back
  acb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Cipher state and result register
  acb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_cmd            (pop_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_plain_byte     (out_plain_byte),
    .out_keystream_byte (out_keystream_byte)
  );

endmodule

// ----- design/acb_front.sv -----
// Front end: takes input beats and classifies them into queue commands.
module acb_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [2:0]        in_load_index,
  input  logic [63:0]       in_load_word,
  input  logic [7:0]        in_cipher_byte,
  input  logic [7:0]        in_ca_byte,
  input  logic [7:0]        in_cb_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output acb_pkg::cmd_t     push_cmd
);
  import acb_pkg::*;

  // Handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Decode function, range-check slice, mask unused bits
  always_comb begin
    push_cmd         = '0;
    push_cmd.load    = (in_func == FUNC_LOAD);
    push_cmd.slice   = in_load_index;
    push_cmd.load_en = (in_func == FUNC_LOAD) && (in_load_index <= SLICE_LAST);
    if (in_load_index == SLICE_LAST) begin
      push_cmd.word = in_load_word & {{(SLICE_BITS-LAST_BITS){1'b0}}, {LAST_BITS{1'b1}}};
    end else begin
      push_cmd.word = in_load_word;
    end
    push_cmd.cbyte = in_cipher_byte & STEP_MASK;
    push_cmd.abyte = in_ca_byte & STEP_MASK;
    push_cmd.bbyte = in_cb_byte & STEP_MASK;
  end

endmodule

// ----- design/acb_queue.sv -----
// Short command queue between the front end and the cipher back end.
module acb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  acb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output acb_pkg::cmd_t pop_cmd
);
  import acb_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- design/acb_back.sv -----
// Back end: holds the cipher state, runs loads and byte decrypts, drives the result register.
module acb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  acb_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_plain_byte,
  output logic [7:0]    out_keystream_byte
);
  import acb_pkg::*;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] plain_r, plain_nxt;
  logic [7:0] ks_r, ks_nxt;
  logic       do_exec;
  step_t      st;

  // Take a command whenever the result register is free or being emptied
  assign pop_ready = !out_valid_r || out_ready;
  assign do_exec   = pop_valid && pop_ready;

  // Execute: slice load or eight unrolled bit updates
  always_comb begin
    state_nxt = state_r;
    plain_nxt = plain_r;
    ks_nxt    = ks_r;
    st        = '0;
    if (do_exec) begin
      plain_nxt = '0;
      ks_nxt    = '0;
      if (pop_cmd.load) begin
        if (pop_cmd.load_en) begin
          case (pop_cmd.slice)
            SLICE_0:    state_nxt[0*SLICE_BITS +: SLICE_BITS] = pop_cmd.word;
            SLICE_1:    state_nxt[1*SLICE_BITS +: SLICE_BITS] = pop_cmd.word;
            SLICE_2:    state_nxt[2*SLICE_BITS +: SLICE_BITS] = pop_cmd.word;
            SLICE_3:    state_nxt[3*SLICE_BITS +: SLICE_BITS] = pop_cmd.word;
            SLICE_LAST: state_nxt[4*SLICE_BITS +: LAST_BITS]  = pop_cmd.word[LAST_BITS-1:0];
            default:    state_nxt = state_r;
          endcase
        end
      end else begin
        for (int i = 0; i < BITS_PER_ITEM; i++) begin
          st = acb_step(state_nxt, pop_cmd.cbyte[i], pop_cmd.abyte[i], pop_cmd.bbyte[i]);
          state_nxt    = st.s;
          plain_nxt[i] = st.p;
          ks_nxt[i]    = st.ks;
        end
      end
    end
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    plain_r <= plain_nxt;
    ks_r    <= ks_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_plain_byte     = plain_r;
  assign out_keystream_byte = ks_r;

endmodule

// ----- dv/acorn128_byte_decrypt_checker.sv -----
// Checker for the ACORN-128 byte decrypt unit: watches both channels, predicts and compares.
module acorn128_byte_decrypt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [2:0]  in_load_index,
  input  logic [63:0] in_load_word,
  input  logic [7:0]  in_cipher_byte,
  input  logic [7:0]  in_ca_byte,
  input  logic [7:0]  in_cb_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_plain_byte,
  input  logic [7:0]  out_keystream_byte,
  output int          fail_count,
  output int          pending
);
  import acb_pkg::*;

  typedef struct packed {
    logic [7:0] plain;
    logic [7:0] ks;
  } plain_ks_t;

  typedef struct packed {
    state_t     s;
    logic [7:0] plain;
    logic [7:0] ks;
  } byte_outcome_t;

  state_t    shadow_state;
  plain_ks_t expected_bytes[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Eight bit updates, bit 0 of each byte first
  function automatic byte_outcome_t decrypt_byte(state_t s, logic [7:0] c, logic [7:0] a,
                                                 logic [7:0] b);
    byte_outcome_t r;
    logic          ks;
    logic          fb;
    logic          pt;
    r.plain = '0;
    r.ks    = '0;
    for (int i = 0; i < BITS_PER_ITEM; i++) begin
      // linear taps, in order; each uses bits not yet touched in this update
      s[289] = s[289] ^ s[235] ^ s[230];
      s[230] = s[230] ^ s[196] ^ s[193];
      s[193] = s[193] ^ s[160] ^ s[154];
      s[154] = s[154] ^ s[111] ^ s[107];
      s[107] = s[107] ^ s[66]  ^ s[61];
      s[61]  = s[61]  ^ s[23]  ^ s[0];
      ks = s[12] ^ s[154]
         ^ ((s[235] & s[61]) | (s[235] & s[193]) | (s[61] & s[193]))
         ^ (s[230] ? s[111] : s[66]);
      fb = s[0] ^ ~s[107]
         ^ ((s[244] & s[23]) | (s[244] & s[160]) | (s[23] & s[160]))
         ^ (a[i] & s[196]) ^ (b[i] & ks);
      pt = ks ^ c[i];
      s  = {fb ^ pt, s[STATE_BITS-1:1]};
      r.plain[i] = pt;
      r.ks[i]    = ks;
    end
    r.s = s;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Pop on result beats first, then predict on input beats
  always @(posedge clk) begin
    byte_outcome_t outcome;
    plain_ks_t     want;
    if (!rst_n) begin
      shadow_state = '0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result beat with nothing waiting", out_plain_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_plain_byte !== want.plain)
            report_mismatch("plain_byte", out_plain_byte, want.plain);
          if (out_keystream_byte !== want.ks)
            report_mismatch("keystream_byte", out_keystream_byte, want.ks);
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_LOAD) begin
          case (in_load_index)
            SLICE_0:    shadow_state[63:0]    = in_load_word;
            SLICE_1:    shadow_state[127:64]  = in_load_word;
            SLICE_2:    shadow_state[191:128] = in_load_word;
            SLICE_3:    shadow_state[255:192] = in_load_word;
            SLICE_LAST: shadow_state[STATE_BITS-1:256] = in_load_word[LAST_BITS-1:0];
            default: ;  // out-of-range slice leaves the state alone
          endcase
          want.plain = '0;
          want.ks    = '0;
        end else begin
          outcome = decrypt_byte(shadow_state, in_cipher_byte, in_ca_byte, in_cb_byte);
          shadow_state = outcome.s;
          want.plain   = outcome.plain;
          want.ks      = outcome.ks;
        end
        expected_bytes.push_back(want);
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ----- dv/acorn128_byte_decrypt_unit_test.sv -----
// Testbench top for the ACORN-128 byte decrypt unit: clock, reset, stimulus and verdict.
module acorn128_byte_decrypt_unit_test;
  import acb_pkg::*;

  localparam int TOTAL_BEATS = 1550;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_AT     = 200;   // result count at which the receiver holds off
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [2:0]  in_load_index;
  logic [63:0] in_load_word;
  logic [7:0]  in_cipher_byte;
  logic [7:0]  in_ca_byte;
  logic [7:0]  in_cb_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_plain_byte;
  logic [7:0]  out_keystream_byte;
  int          fail_count;
  int          pending;

  int          beats_sent;
  int          results_taken;
  int          idle_cycles;
  bit          send_quiet;
  bit          take_quiet;

  acorn128_byte_decrypt_unit DUT (.*);
  acorn128_byte_decrypt_checker CHK (.*);

  always #2 clk = ~clk;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input logic func, input logic [2:0] idx, input logic [63:0] word,
                           input logic [7:0] c, input logic [7:0] a, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_load_index  <= idx;
    in_load_word   <= word;
    in_cipher_byte <= c;
    in_ca_byte     <= a;
    in_cb_byte     <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_decrypt(input logic [7:0] c, input logic [7:0] a, input logic [7:0] b);
    send_beat(FUNC_DECRYPT, 3'($urandom_range(0, 7)), rand_word(), c, a, b);
  endtask

  task automatic send_load(input logic [2:0] idx, input logic [63:0] word);
    send_beat(FUNC_LOAD, idx, word, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_directed();
    // zero state, then all-ones state
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'h00, 8'h00, 8'h00);
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'hFF, 8'hFF, 8'hFF);
    send_load(SLICE_0, '1);
    send_load(SLICE_1, '1);
    send_load(SLICE_2, '1);
    send_load(SLICE_3, '1);
    send_load(SLICE_LAST, '1);       // only the low bits of the top slice land
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'h00, 8'hFF, 8'h00);
    // decrypt beat with load fields at their extremes: ignored
    send_beat(FUNC_DECRYPT, 3'd7, '1, 8'hFF, 8'h00, 8'hFF);
    // out-of-range slices, with byte fields set: no state change
    send_beat(FUNC_LOAD, 3'd5, '1, 8'hFF, 8'hFF, 8'hFF);
    send_beat(FUNC_LOAD, 3'd6, 64'h5555_AAAA_5555_AAAA, 8'h00, 8'hFF, 8'h00);
    send_beat(FUNC_LOAD, 3'd7, '0, 8'h00, 8'h00, 8'h00);
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'hA5, 8'h5A, 8'hC3);
    // back to zero; top slice gets only ignored upper bits set
    send_load(SLICE_0, '0);
    send_load(SLICE_1, '0);
    send_load(SLICE_2, '0);
    send_load(SLICE_3, '0);
    send_load(SLICE_LAST, 64'hFFFF_FFE0_0000_0000);
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'h00, 8'h00, 8'h00);
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'hFF, 8'hFF, 8'hFF);
    send_beat(FUNC_DECRYPT, SLICE_0, '0, 8'h01, 8'h80, 8'h7F);
  endtask

  task automatic run_random();
    int kind;
    int runs;
    while (beats_sent < TOTAL_BEATS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // full key load in order or reversed, then a stream of ciphertext
        if ($urandom_range(0, 1) == 0) begin
          for (int s = 0; s <= SLICE_LAST; s++) send_load(3'(s), rand_word());
        end else begin
          for (int s = SLICE_LAST; s >= 0; s--) send_load(3'(s), rand_word());
        end
        runs = $urandom_range(1, 24);
        repeat (runs) send_decrypt(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind <= 8) begin
        // noise: anything the fields allow
        send_beat(1'($urandom), 3'($urandom), rand_word(), 8'($urandom), 8'($urandom),
                  8'($urandom));
      end else begin
        // broken load: a few slices, some out of range, then a short stream
        runs = $urandom_range(1, 4);
        repeat (runs) send_load(3'($urandom_range(0, 7)), rand_word());
        runs = $urandom_range(1, 6);
        repeat (runs) send_decrypt(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_DECRYPT;
    in_load_index  <= SLICE_0;
    in_load_word   <= '0;
    in_cipher_byte <= '0;
    in_ca_byte     <= '0;
    in_cb_byte     <= '0;
    beats_sent     = 0;
    send_quiet     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // wait so the count includes the last beat, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off so the queue fills
  initial begin
    int gap;
    out_ready     <= 1'b0;
    results_taken = 0;
    take_quiet    = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) take_quiet = !take_quiet;
      gap = take_quiet ? 0 : $urandom_range(0, 14);
      if (results_taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
